[rtl/ppgs_pkg.sv]
// Shared types, codes and cell helpers for the predator/prey grid sweep unit.
`timescale 1ns / 1ps

package ppgs_pkg;

  localparam int KIND_W  = 2;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 16;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FISH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHARK = 2'd2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [1:0] CFG_FISH_SPAWN_AGE = 2'd0;
  localparam logic [1:0] CFG_MEAL_ENERGY    = 2'd1;
  localparam logic [1:0] CFG_SPLIT_ENERGY   = 2'd2;

  localparam logic [7:0]         RST_FISH_SPAWN_AGE = 8'd12;
  localparam logic [COUNT_W-1:0] RST_MEAL_ENERGY    = 16'd10;
  localparam logic [COUNT_W-1:0] RST_SPLIT_ENERGY   = 16'd250;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COUNT_W-1:0] count;
  } cell_t;

  typedef struct packed {
    logic [7:0]         fish_spawn_age;
    logic [COUNT_W-1:0] meal_energy;
    logic [COUNT_W-1:0] split_energy;
  } cfg_t;

  // Anything other than fish or shark is stored as an empty cell.
  function automatic cell_t cell_put(input logic [KIND_W-1:0] kind,
                                     input logic [COUNT_W-1:0] count);
    cell_t c;
    if (kind == KIND_FISH || kind == KIND_SHARK) begin
      c.kind  = kind;
      c.count = count;
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

[rtl/ppgs_grid_mem.sv]
// Dual-port grid store, one cell per entry, registered reads.
`timescale 1ns / 1ps

module ppgs_grid_mem #(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              a_we,
  input  logic [AW-1:0]     a_addr,
  input  ppgs_pkg::cell_t   a_wdata,
  output ppgs_pkg::cell_t   a_rdata,
  input  logic              b_we,
  input  logic [AW-1:0]     b_addr,
  input  ppgs_pkg::cell_t   b_wdata,
  output ppgs_pkg::cell_t   b_rdata
);
  import ppgs_pkg::*;

  localparam int DEPTH = 1 << AW;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem[a_addr] <= a_wdata;
    end
    if (b_we) begin
      mem[b_addr] <= b_wdata;
    end
    a_rdata <= mem[a_addr];
    b_rdata <= mem[b_addr];
  end

endmodule

[rtl/ppgs_rules.sv]
// Move, spawn, feed and starve rules for one visited cell and its target.
`timescale 1ns / 1ps

module ppgs_rules (
  input  ppgs_pkg::cfg_t  cfg,
  input  ppgs_pkg::cell_t here,
  input  ppgs_pkg::cell_t there,
  output ppgs_pkg::cell_t here_new,
  output ppgs_pkg::cell_t there_new
);
  import ppgs_pkg::*;

  logic [COUNT_W-1:0] addend;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] sat_sum;
  logic [COUNT_W-1:0] dec;
  logic [COUNT_W-1:0] half;
  logic               alive;

  // one adder: +1 for an ageing fish, +meal for a feeding shark
  assign addend  = (here.kind == KIND_FISH) ? COUNT_W'(1) : cfg.meal_energy;
  assign sum     = {1'b0, here.count} + {1'b0, addend};
  assign sat_sum = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
  assign dec     = here.count - COUNT_W'(1);
  assign half    = {1'b0, here.count[COUNT_W-1:1]};
  assign alive   = here.count > COUNT_W'(1);

  always_comb begin
    here_new  = here;
    there_new = there;
    if (here.kind == KIND_FISH) begin
      if (there.kind == KIND_EMPTY) begin
        if (COUNT_W'(cfg.fish_spawn_age) <= here.count) begin
          here_new  = '{kind: KIND_FISH, count: '0};
          there_new = '{kind: KIND_FISH, count: '0};
        end else begin
          here_new  = '0;
          there_new = '{kind: KIND_FISH, count: sat_sum};
        end
      end
    end else if (here.kind == KIND_SHARK) begin
      priority if (there.kind == KIND_EMPTY) begin
        if (here.count > cfg.split_energy) begin
          here_new  = '{kind: KIND_SHARK, count: half};
          there_new = '{kind: KIND_SHARK, count: half};
        end else if (alive) begin
          here_new  = '0;
          there_new = '{kind: KIND_SHARK, count: dec};
        end else begin
          here_new  = '0;
        end
      end else if (there.kind == KIND_FISH) begin
        here_new  = '0;
        there_new = '{kind: KIND_SHARK, count: sat_sum};
      end else begin
        if (alive) begin
          here_new = '{kind: KIND_SHARK, count: dec};
        end else begin
          here_new = '0;
        end
      end
    end
  end

endmodule

[rtl/predator_prey_grid_sweep_unit.sv]
// Top level: command decode, scan counters, config registers and grid sequencing.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------------
//   command  | start / busy       | op, cell_x, cell_y, kind_in, count_in, direction
//   result   | done (1-cycle)     | kind_out, count_out, visit_x, visit_y, sweep_done
//   config   | cfg_we             | cfg_index, cfg_data
//
// Each item is handled thus: the accepting edge reads the grid (both ports for a
// step, here and target cell), the next edge writes back and registers the
// result, and done is high in the cycle after. A new item may be accepted then.
// After reset a clearing pass empties all 2^(XW+YW) grid entries (4096 at 64x64),
// with busy high; config writes are taken during it. Results cannot be stalled.
`timescale 1ns / 1ps

module predator_prey_grid_sweep_unit #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [1:0]  kind_in,
  input  logic [15:0] count_in,
  input  logic [1:0]  direction,
  output logic        done,
  output logic [1:0]  kind_out,
  output logic [15:0] count_out,
  output logic [5:0]  visit_x,
  output logic [5:0]  visit_y,
  output logic        sweep_done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ppgs_pkg::*;

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int AW = XW + YW;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  cfg_t          cfg;
  logic [XW-1:0] scan_col;
  logic [YW-1:0] scan_row;

  logic [XW-1:0] xmod_tab [64];
  logic [YW-1:0] ymod_tab [64];

  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          accept;
  logic          scan_last_col;
  logic          scan_last_row;
  logic [AW-1:0] rd_addr_a;

  logic [1:0]    op_q;
  logic [AW-1:0] addr_a_q;
  logic [AW-1:0] addr_b_q;
  cell_t         wcell_q;
  logic [XW-1:0] vx_q;
  logic [YW-1:0] vy_q;
  logic          last_q;

  logic          a_we;
  logic [AW-1:0] a_addr;
  cell_t         a_wdata;
  cell_t         a_rdata;
  logic          b_we;
  logic [AW-1:0] b_addr;
  cell_t         b_wdata;
  cell_t         b_rdata;
  cell_t         here_new;
  cell_t         there_new;

  // cell address reduction tables, fixed at elaboration
  for (genvar i = 0; i < 64; i++) begin : g_mod
    assign xmod_tab[i] = XW'(i % GRID_WIDTH);
    assign ymod_tab[i] = YW'(i % GRID_HEIGHT);
  end

  assign busy          = (state != ST_IDLE);
  assign accept        = start && (state == ST_IDLE);
  assign scan_last_col = (scan_col == XW'(GRID_WIDTH - 1));
  assign scan_last_row = (scan_row == YW'(GRID_HEIGHT - 1));
  assign rd_addr_a     = (op == OP_STEP) ? {scan_row, scan_col}
                                         : {ymod_tab[cell_y], xmod_tab[cell_x]};

  always_comb begin
    nx = scan_col;
    ny = scan_row;
    unique case (direction)
      DIR_UP:    ny = (scan_row == '0) ? YW'(GRID_HEIGHT - 1) : scan_row - YW'(1);
      DIR_RIGHT: nx = scan_last_col ? '0 : scan_col + XW'(1);
      DIR_DOWN:  ny = scan_last_row ? '0 : scan_row + YW'(1);
      DIR_LEFT:  nx = (scan_col == '0) ? XW'(GRID_WIDTH - 1) : scan_col - XW'(1);
      default:   ny = scan_row;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      scan_col <= '0;
      scan_row <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state <= ST_EXEC;
            if (op == OP_STEP) begin
              if (scan_last_row) begin
                scan_row <= '0;
                scan_col <= scan_last_col ? '0 : scan_col + XW'(1);
              end else begin
                scan_row <= scan_row + YW'(1);
              end
            end
          end
        end
        ST_EXEC: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= op;
      addr_a_q <= rd_addr_a;
      addr_b_q <= {ny, nx};
      wcell_q  <= cell_put(kind_in, count_in);
      vx_q     <= scan_col;
      vy_q     <= scan_row;
      last_q   <= scan_last_col && scan_last_row;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fish_spawn_age <= RST_FISH_SPAWN_AGE;
      cfg.meal_energy    <= RST_MEAL_ENERGY;
      cfg.split_energy   <= RST_SPLIT_ENERGY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FISH_SPAWN_AGE: cfg.fish_spawn_age <= cfg_data[7:0];
        CFG_MEAL_ENERGY:    cfg.meal_energy    <= cfg_data;
        CFG_SPLIT_ENERGY:   cfg.split_energy   <= cfg_data;
        default:            cfg.split_energy   <= cfg.split_energy;
      endcase
    end
  end

  // grid port steering
  always_comb begin
    a_we    = 1'b0;
    a_addr  = rd_addr_a;
    a_wdata = '0;
    b_we    = 1'b0;
    b_addr  = {ny, nx};
    b_wdata = there_new;
    unique case (state)
      ST_CLEAR: begin
        a_we   = 1'b1;
        a_addr = clr_addr;
      end
      ST_EXEC: begin
        a_addr  = addr_a_q;
        b_addr  = addr_b_q;
        a_we    = (op_q == OP_WRITE) || (op_q == OP_STEP);
        b_we    = (op_q == OP_STEP);
        a_wdata = (op_q == OP_STEP) ? here_new : wcell_q;
      end
      default: a_we = 1'b0;
    endcase
  end

  ppgs_grid_mem #(
    .AW(AW)
  ) u_grid_mem (
    .clk     (clk),
    .a_we    (a_we),
    .a_addr  (a_addr),
    .a_wdata (a_wdata),
    .a_rdata (a_rdata),
    .b_we    (b_we),
    .b_addr  (b_addr),
    .b_wdata (b_wdata),
    .b_rdata (b_rdata)
  );

  ppgs_rules u_rules (
    .cfg       (cfg),
    .here      (a_rdata),
    .there     (b_rdata),
    .here_new  (here_new),
    .there_new (there_new)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      unique case (op_q)
        OP_WRITE: begin
          kind_out   <= wcell_q.kind;
          count_out  <= wcell_q.count;
          visit_x    <= '0;
          visit_y    <= '0;
          sweep_done <= 1'b0;
        end
        OP_READ: begin
          kind_out   <= a_rdata.kind;
          count_out  <= a_rdata.count;
          visit_x    <= '0;
          visit_y    <= '0;
          sweep_done <= 1'b0;
        end
        OP_STEP: begin
          kind_out   <= here_new.kind;
          count_out  <= here_new.count;
          visit_x    <= 6'(vx_q);
          visit_y    <= 6'(vy_q);
          sweep_done <= last_q;
        end
        default: begin
          kind_out   <= '0;
          count_out  <= '0;
          visit_x    <= '0;
          visit_y    <= '0;
          sweep_done <= 1'b0;
        end
      endcase
    end
  end

endmodule
